// ===== rtl/pace_pkg.sv =====
// Shared types and constants for the postfix accumulator code emitter.
// No dependencies.
package pace_pkg;

    localparam int SYM_W     = 8;
    localparam int VAL_W     = 8;
    localparam int S_DATA_W  = 8;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 16;
    localparam int M_USER_W  = 2;

    localparam logic [SYM_W-1:0] SYM_ADD = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV = 8'h2F;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_OP    = 2'd1,
        KIND_STORE = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OPC_ADD = 2'd0,
        OPC_SUB = 2'd1,
        OPC_MUL = 2'd2,
        OPC_DIV = 2'd3
    } opcode_t;

    typedef enum logic {
        ERR_UNDERFLOW = 1'b0,
        ERR_OVERFLOW  = 1'b1
    } err_code_t;

    typedef enum logic [1:0] {
        BEAT_LOAD  = 2'd0,
        BEAT_OP    = 2'd1,
        BEAT_STORE = 2'd2
    } beat_t;

    // one stack entry: temp tag and the letter symbol or temp number
    typedef struct packed {
        logic             tag;
        logic [VAL_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // everything one item leaves for the result channel
    typedef struct packed {
        logic             is_err;
        err_code_t        err_code;
        opcode_t          opcode;
        entry_t           left;
        entry_t           right;
        logic [VAL_W-1:0] tnum;
    } rec_t;

endpackage

// ===== rtl/pace_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pace_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== rtl/postfix_accumulator_code_emitter.sv =====
// Postfix to accumulator code emitter: top two stack entries in registers, rest in pace_ram.
// The first result beat is registered and valid in the cycle after the input beat is accepted, if the port is idle.
// Letters and ignored symbols are accepted one beat per cycle while s_tready is high; an operator
// holds the result port for three beats and an error for one.
// Reset (aresetn, synchronous) clears stack count, temp counter, error latch and queue;
// the stack memory is not cleared and no clearing pass is needed.
module postfix_accumulator_code_emitter #(
    parameter int STACK_DEPTH = 128,
    parameter int TEMP_BITS   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pace_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] symbol
    input  logic [pace_pkg::S_USER_W-1:0] s_tuser,  // [0] first
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pace_pkg::M_DATA_W-1:0] m_tdata,  // [1:0] opcode, [2] is_temp,
                                                    // [10:3] operand, [11] error_code
    output logic [pace_pkg::M_USER_W-1:0] m_tuser,  // [1:0] kind
    output logic                          m_tlast
);

    import pace_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // stack and expression state
    logic [CW-1:0]        count_reg, count_next;
    logic [TEMP_BITS-1:0] temp_reg, temp_next;
    logic                 err_reg, err_next;
    entry_t               top_reg, top_next;
    entry_t               second_reg, second_next;
    logic                 fwd_valid_reg;
    entry_t               fwd_data_reg;

    // result queue
    rec_t                 out_rec_reg, hold_rec_reg;
    logic                 out_valid_reg, hold_valid_reg;
    beat_t                beat_reg;

    logic                 accept;
    logic                 first;
    logic [SYM_W-1:0]     symbol;
    logic [CW-1:0]        eff_count;
    logic [TEMP_BITS-1:0] eff_temp, new_temp;
    logic                 eff_err;
    logic                 is_letter, is_op;
    opcode_t              op;
    entry_t               mem_top;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    rec_t                 new_rec;
    logic                 new_valid;
    logic                 last_beat, out_done, out_free;

    assign accept = s_tvalid && s_tready;
    assign first  = s_tuser[0];
    assign symbol = s_tdata[SYM_W-1:0];

    assign eff_count = first ? '0 : count_reg;
    assign eff_temp  = first ? '0 : temp_reg;
    assign eff_err   = first ? 1'b0 : err_reg;
    assign new_temp  = eff_temp + TEMP_BITS'(1);
    assign mem_top   = fwd_valid_reg ? fwd_data_reg : entry_t'(ram_rdata);

    always_comb begin
        is_letter = symbol inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_op     = 1'b1;
        op        = OPC_ADD;
        case (symbol)
            SYM_ADD: op = OPC_ADD;
            SYM_SUB: op = OPC_SUB;
            SYM_MUL: op = OPC_MUL;
            SYM_DIV: op = OPC_DIV;
            default: is_op = 1'b0;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        temp_next   = temp_reg;
        err_next    = err_reg;
        top_next    = top_reg;
        second_next = second_reg;
        ram_we      = 1'b0;
        new_valid   = 1'b0;
        new_rec     = '0;
        new_rec.left  = second_reg;
        new_rec.right = top_reg;
        new_rec.tnum  = VAL_W'(new_temp);
        new_rec.opcode = op;
        if (accept) begin
            count_next = eff_count;
            temp_next  = eff_temp;
            err_next   = eff_err;
            if (!eff_err) begin
                if (is_letter) begin
                    if (eff_count == CW'(STACK_DEPTH)) begin
                        err_next         = 1'b1;
                        new_valid        = 1'b1;
                        new_rec.is_err   = 1'b1;
                        new_rec.err_code = ERR_OVERFLOW;
                    end else begin
                        ram_we      = eff_count >= CW'(2);
                        second_next = top_reg;
                        top_next    = '{tag: 1'b0, val: symbol};
                        count_next  = eff_count + CW'(1);
                    end
                end else if (is_op) begin
                    if (eff_count < CW'(2)) begin
                        err_next         = 1'b1;
                        new_valid        = 1'b1;
                        new_rec.is_err   = 1'b1;
                        new_rec.err_code = ERR_UNDERFLOW;
                    end else begin
                        new_valid   = 1'b1;
                        top_next    = '{tag: 1'b1, val: VAL_W'(new_temp)};
                        second_next = mem_top;
                        count_next  = eff_count - CW'(1);
                        temp_next   = new_temp;
                    end
                end
            end
        end
    end

    // memory holds entries below the top two; read port tracks the next one down
    assign ram_waddr = AW'(eff_count - CW'(2));
    assign ram_raddr = AW'(count_next - CW'(3));

    pace_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(second_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign last_beat = out_rec_reg.is_err || (beat_reg == BEAT_STORE);
    assign out_done  = out_valid_reg && m_tready && last_beat;
    assign out_free  = !out_valid_reg || out_done;
    assign s_tready  = !hold_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            temp_reg       <= '0;
            err_reg        <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            beat_reg       <= BEAT_LOAD;
        end else begin
            count_reg     <= count_next;
            temp_reg      <= temp_next;
            err_reg       <= err_next;
            fwd_valid_reg <= ram_we;
            if (out_free) begin
                beat_reg <= BEAT_LOAD;
                if (hold_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= new_valid;
                end
            end else begin
                if (m_tready) begin
                    beat_reg <= beat_t'(beat_reg + 2'd1);
                end
                if (new_valid) begin
                    hold_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        second_reg   <= second_next;
        fwd_data_reg <= second_reg;
        if (out_free) begin
            out_rec_reg <= hold_valid_reg ? hold_rec_reg : new_rec;
        end else if (new_valid) begin
            hold_rec_reg <= new_rec;
        end
    end

    kind_t            o_kind;
    opcode_t          o_opcode;
    logic             o_is_temp;
    logic [VAL_W-1:0] o_operand;

    always_comb begin
        o_kind    = KIND_ERROR;
        o_opcode  = OPC_ADD;
        o_is_temp = 1'b0;
        o_operand = '0;
        if (!out_rec_reg.is_err) begin
            case (beat_reg)
                BEAT_LOAD: begin
                    o_kind    = KIND_LOAD;
                    o_is_temp = out_rec_reg.left.tag;
                    o_operand = out_rec_reg.left.val;
                end
                BEAT_OP: begin
                    o_kind    = KIND_OP;
                    o_opcode  = out_rec_reg.opcode;
                    o_is_temp = out_rec_reg.right.tag;
                    o_operand = out_rec_reg.right.val;
                end
                BEAT_STORE: begin
                    o_kind    = KIND_STORE;
                    o_is_temp = 1'b1;
                    o_operand = out_rec_reg.tnum;
                end
                default: begin
                    o_kind = KIND_ERROR;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = o_kind;
    assign m_tdata  = {4'b0000,
                       out_rec_reg.is_err ? out_rec_reg.err_code : ERR_UNDERFLOW,
                       o_operand, o_is_temp, o_opcode};

    a_hold_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> out_valid_reg)
        else $error("queue holds a record behind an empty output slot");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rec_reg.is_err) |-> (beat_reg == BEAT_LOAD))
        else $error("error record past its only beat");

    a_first_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && first && is_letter) |=> (count_reg == CW'(1) && !err_reg))
        else $error("first letter did not restart the stack");

endmodule
